### rtl/core/pf_pkg.sv
// pf_pkg: shared types and constants for the prime factorizer.
// Holds the microcode control word, status bundle and jump conditions.
// No dependencies.
`timescale 1ns / 1ps

package pf_pkg;

    localparam int VALUE_BITS    = 32;  // input and prime field width
    localparam int EXP_BITS      = 5;   // exponent field width
    localparam int OUT_DATA_BITS = 40;  // prime + exponent, padded to bytes
    localparam int ADDR_BITS     = 4;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [EXP_BITS-1:0]  t_exp;

    // jump conditions of a microcode step
    typedef enum logic [2:0] {
        C_NEXT      = 3'd0,
        C_ALWAYS    = 3'd1,
        C_NO_ITEM   = 3'd2,
        C_REM_LT2   = 3'd3,
        C_SQ_GT_REM = 3'd4,
        C_DIV_BUSY  = 3'd5,
        C_DIV_REM_NZ = 3'd6,
        C_POW_ZERO  = 3'd7
    } t_cond;

    typedef struct packed {
        logic  take;        // offer input ready, load item on accept
        logic  sq;          // register divisor squared
        logic  clr_pow;     // clear exponent count
        logic  div_start;   // start trial division
        logic  div_commit;  // remainder <= quotient, exponent + 1
        logic  wheel;       // advance to next trial divisor
        logic  post;        // new factor into pending slot
        logic  post_rem;    // pending source: remainder rather than divisor
        logic  flush;       // pending result out, flagged last
        logic  none;        // no-factor result out
        logic  wait_out;    // hold step while output register is full
        t_cond cond;
        t_addr target;
    } t_cw;

    typedef struct packed {
        logic no_item;
        logic rem_lt2;
        logic sq_gt_rem;
        logic div_busy;
        logic div_rem_nz;
        logic pow_zero;
        logic out_full;
    } t_status;

endpackage

### rtl/core/prime_factorizer.sv
// prime_factorizer: top level, datapath around the microcode sequencer.
// Depends on pf_pkg, pf_sequencer and pf_divider.
//
// Usage: one unsigned value enters on the slave stream (i_s_*). Its distinct
// prime factors leave on the master stream (o_m_*) in ascending order, each
// with its exponent; tlast marks the final item of a value. Values 0 and 1
// give a single item with tuser (has_factor) low and tlast high.
// Trial divisors are 2, 3, then 6k-1 / 6k+1, tried while divisor squared
// does not exceed the remainder; a leftover remainder is the last prime.
// Each trial divisor runs the bit-serial divider (one quotient bit a cycle)
// plus the squaring and test steps; each division that succeeds runs the
// divider again with the quotient. Worst case (a large prime near 2^32) is
// roughly 21845 trial divisors. One value is worked on at a time; ready is
// high only at the idle step, which may overlap a result still waiting in
// the output register. A stalled receiver holds the output item and stops
// the sequencer at its next emitting step. Synchronous reset returns the
// sequencer to idle and empties the output and pending registers.
`timescale 1ns / 1ps

module prime_factorizer
    import pf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [VALUE_BITS-1:0]    i_s_tdata,   // [31:0] value_in
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,   // [31:0] prime_factor, [36:32] exponent
    output logic                     o_m_tuser,   // [0] has_factor
    output logic                     o_m_tlast    // is_last
);

    localparam int W = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;

    t_cw     cw;
    logic    fire;
    t_status status;
    logic    accept;

    logic         div_busy;
    logic [W-1:0] div_q;
    logic [W-1:0] div_r;

    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_div;
    logic [2*W-1:0] r_sq;
    t_exp           r_pow;
    logic           r_phase;

    // one result held back so the last one can be flagged
    logic           r_pend_valid;
    logic [W-1:0]   r_pend_prime;
    t_exp           r_pend_exp;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_prime;
    t_exp                  r_out_exp;
    logic                  r_out_has;
    logic                  r_out_last;

    pf_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cw     (cw),
        .o_fire   (fire)
    );

    pf_divider #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (fire && cw.div_start),
        .i_dividend  (r_rem),
        .i_divisor   (r_div),
        .o_busy      (div_busy),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    assign o_s_tready = cw.take;
    assign accept     = i_s_tvalid && cw.take;

    always_comb begin
        status.no_item    = !i_s_tvalid;
        status.rem_lt2    = (r_rem < W'(2));
        status.sq_gt_rem  = (r_sq > (2*W)'(r_rem));
        status.div_busy   = div_busy;
        status.div_rem_nz = |div_r;
        status.pow_zero   = (r_pow == '0);
        status.out_full   = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem        <= '0;
            r_div        <= W'(2);
            r_pow        <= '0;
            r_phase      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready)
                r_out_valid <= 1'b0;
            if (accept) begin
                r_rem   <= i_s_tdata[W-1:0];
                r_div   <= W'(2);
                r_pow   <= '0;
                r_phase <= 1'b0;
            end
            if (fire) begin
                if (cw.sq)
                    r_sq <= r_div * r_div;
                if (cw.clr_pow)
                    r_pow <= '0;
                if (cw.div_commit) begin
                    r_rem <= div_q;
                    r_pow <= r_pow + t_exp'(1);
                end
                if (cw.wheel) begin
                    if (r_div == W'(2)) begin
                        r_div <= W'(3);
                    end else if (r_div == W'(3)) begin
                        r_div   <= W'(5);
                        r_phase <= 1'b0;
                    end else begin
                        r_div   <= r_div + (r_phase ? W'(4) : W'(2));
                        r_phase <= !r_phase;
                    end
                end
                if (cw.post) begin
                    if (r_pend_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_prime <= VALUE_BITS'(r_pend_prime);
                        r_out_exp   <= r_pend_exp;
                        r_out_has   <= 1'b1;
                        r_out_last  <= 1'b0;
                    end
                    r_pend_valid <= 1'b1;
                    r_pend_prime <= cw.post_rem ? r_rem : r_div;
                    r_pend_exp   <= cw.post_rem ? t_exp'(1) : r_pow;
                end
                if (cw.flush) begin
                    r_out_valid  <= 1'b1;
                    r_out_prime  <= VALUE_BITS'(r_pend_prime);
                    r_out_exp    <= r_pend_exp;
                    r_out_has    <= 1'b1;
                    r_out_last   <= 1'b1;
                    r_pend_valid <= 1'b0;
                end
                if (cw.none) begin
                    r_out_valid <= 1'b1;
                    r_out_prime <= '0;
                    r_out_exp   <= '0;
                    r_out_has   <= 1'b0;
                    r_out_last  <= 1'b1;
                end
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_BITS - VALUE_BITS - EXP_BITS)'(0), r_out_exp, r_out_prime};
    assign o_m_tuser  = r_out_has;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    // a new value never finds a result left over from the previous one
    a_idle_pend_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !r_pend_valid)
        else $error("pending result present at input accept");

    // a flush, the last item of a value that has factors, always comes from a held result
    a_flush_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && cw.flush) |-> r_pend_valid)
        else $error("flush with no pending result");

    // quotient is only taken from a finished, exact division
    a_commit_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && cw.div_commit) |-> (!div_busy && div_r == '0))
        else $error("commit of unfinished or inexact division");

    // divisor never drops below two, so the divider never sees 0 or 1
    a_divisor_ge2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div >= W'(2))
        else $error("trial divisor below two");
`endif

endmodule

### rtl/core/pf_divider.sv
// pf_divider: restoring divider, one quotient bit per cycle.
// Outputs hold while idle.
// Depends on nothing.
`timescale 1ns / 1ps

module pf_divider #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CNT_BITS = $clog2(W + 1);

    logic [W-1:0]        r_q;
    logic [W-1:0]        r_r;
    logic [W-1:0]        r_d;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;

    logic [W:0] shifted;
    logic [W:0] diff;

    always_comb begin
        shifted = {r_r, r_q[W-1]};
        diff    = shifted - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_q    <= i_dividend;
            r_r    <= '0;
            r_d    <= i_divisor;
            r_cnt  <= CNT_BITS'(W);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            // partial remainder stays below the divisor, so W bits suffice
            if (!diff[W]) begin
                r_r <= diff[W-1:0];
                r_q <= {r_q[W-2:0], 1'b1};
            end else begin
                r_r <= shifted[W-1:0];
                r_q <= {r_q[W-2:0], 1'b0};
            end
            r_cnt  <= r_cnt - CNT_BITS'(1);
            r_busy <= (r_cnt != CNT_BITS'(1));
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_q;
    assign o_remainder = r_r;

endmodule

### rtl/core/pf_sequencer.sv
// pf_sequencer: step counter, microcode ROM and jump logic.
// Issues one control word per step; depends on pf_pkg.
`timescale 1ns / 1ps

module pf_sequencer
    import pf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cw     o_cw,
    output logic    o_fire
);

    localparam t_addr A_IDLE   = t_addr'(0);
    localparam t_addr A_TEST   = t_addr'(2);
    localparam t_addr A_DIVIDE = t_addr'(4);
    localparam t_addr A_WAIT   = t_addr'(5);
    localparam t_addr A_NOFAC  = t_addr'(8);
    localparam t_addr A_WHEEL  = t_addr'(10);
    localparam t_addr A_TAIL   = t_addr'(11);
    localparam t_addr A_FLUSH  = t_addr'(13);
    localparam t_addr A_NONE   = t_addr'(14);

    function automatic t_cw uc_rom(input t_addr a);
        t_cw cw;
        cw = '0;
        cw.cond   = C_NEXT;
        cw.target = A_IDLE;
        case (a)
            4'd0: begin cw.take = 1'b1; cw.cond = C_NO_ITEM; cw.target = A_IDLE; end
            4'd1: begin cw.cond = C_REM_LT2; cw.target = A_NONE; end
            4'd2: begin cw.sq = 1'b1; cw.clr_pow = 1'b1; end
            4'd3: begin cw.cond = C_SQ_GT_REM; cw.target = A_TAIL; end
            4'd4: begin cw.div_start = 1'b1; end
            4'd5: begin cw.cond = C_DIV_BUSY; cw.target = A_WAIT; end
            4'd6: begin cw.cond = C_DIV_REM_NZ; cw.target = A_NOFAC; end
            4'd7: begin cw.div_commit = 1'b1; cw.cond = C_ALWAYS; cw.target = A_DIVIDE; end
            4'd8: begin cw.cond = C_POW_ZERO; cw.target = A_WHEEL; end
            4'd9: begin cw.post = 1'b1; cw.wait_out = 1'b1; end
            4'd10: begin cw.wheel = 1'b1; cw.cond = C_ALWAYS; cw.target = A_TEST; end
            4'd11: begin cw.cond = C_REM_LT2; cw.target = A_FLUSH; end
            4'd12: begin
                cw.post = 1'b1; cw.post_rem = 1'b1; cw.wait_out = 1'b1;
            end
            4'd13: begin
                cw.flush = 1'b1; cw.wait_out = 1'b1;
                cw.cond = C_ALWAYS; cw.target = A_IDLE;
            end
            4'd14: begin
                cw.none = 1'b1; cw.wait_out = 1'b1;
                cw.cond = C_ALWAYS; cw.target = A_IDLE;
            end
            default: begin cw.cond = C_ALWAYS; cw.target = A_IDLE; end
        endcase
        return cw;
    endfunction

    t_addr r_pc;
    t_addr n_pc;
    t_cw   cw;
    logic  jump;
    logic  stall;

    always_comb begin
        cw    = uc_rom(r_pc);
        stall = cw.wait_out && i_status.out_full;
        unique case (cw.cond)
            C_NEXT:       jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NO_ITEM:    jump = i_status.no_item;
            C_REM_LT2:    jump = i_status.rem_lt2;
            C_SQ_GT_REM:  jump = i_status.sq_gt_rem;
            C_DIV_BUSY:   jump = i_status.div_busy;
            C_DIV_REM_NZ: jump = i_status.div_rem_nz;
            C_POW_ZERO:   jump = i_status.pow_zero;
            default:      jump = 1'b0;
        endcase
        if (stall)
            n_pc = r_pc;
        else if (jump)
            n_pc = cw.target;
        else
            n_pc = r_pc + t_addr'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_cw   = cw;
    assign o_fire = !stall;

endmodule

### sim/prime_factorizer_test.sv
// prime_factorizer_test: stream testbench for the prime factorizer.
// Predicts each value's factor items by trial division and checks them in order.
// Depends on pf_pkg and the prime_factorizer RTL.
`timescale 1ns / 1ps

module prime_factorizer_test;
    import pf_pkg::*;

    typedef struct packed {
        logic [VALUE_BITS-1:0] prime;
        t_exp                  power;
        logic                  has_factor;
        logic                  last;
    } t_factor;

    logic                     i_clk;
    logic                     i_rst_n    = 1'b0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [VALUE_BITS-1:0]    i_s_tdata  = '0;   // [31:0] value_in
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;         // [31:0] prime_factor, [36:32] exponent
    logic                     o_m_tuser;         // [0] has_factor
    logic                     o_m_tlast;         // is_last

    logic [VALUE_BITS-1:0] pending_values[$];
    t_factor               expected_factors[$];

    int mismatches    = 0;
    int values_total  = 0;
    int values_taken  = 0;
    int results_seen  = 0;
    int tx_gap        = 0;
    int rx_wait       = 0;
    int hold_left     = 0;
    logic hold_done   = 1'b0;

    prime_factorizer dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // every third run of twenty items goes without idling
    function automatic int idle_draw(input int n);
        if ((n / 20) % 3 == 1)
            return 0;
        return int'($urandom_range(0, 18));
    endfunction

    // trial division on the 6k+-1 wheel; queues one item per distinct prime, or one no-factor item below two
    function automatic void factorize_value(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] rest;
        logic [VALUE_BITS-1:0] divisor;
        t_exp                  count;
        logic                  step_four;
        t_factor               found[$];
        rest = value;
        if (rest < 2) begin
            expected_factors.insert(expected_factors.size(),
                '{prime: '0, power: '0, has_factor: 1'b0, last: 1'b1});
            return;
        end
        divisor   = 2;
        step_four = 1'b0;
        while ({32'd0, divisor} * {32'd0, divisor} <= {32'd0, rest}) begin
            count = '0;
            while (rest % divisor == 0) begin
                rest  = rest / divisor;
                count = count + 1'b1;
            end
            if (count != 0 && found.size() < 9)
                found.insert(found.size(),
                    '{prime: divisor, power: count, has_factor: 1'b1, last: 1'b0});
            if (divisor == 2) begin
                divisor = 3;
            end else if (divisor == 3) begin
                divisor   = 5;
                step_four = 1'b0;
            end else begin
                divisor   = divisor + (step_four ? 4 : 2);
                step_four = ~step_four;
            end
        end
        if (rest > 1 && found.size() < 9)
            found.insert(found.size(),
                '{prime: rest, power: 5'd1, has_factor: 1'b1, last: 1'b0});
        found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            expected_factors.insert(expected_factors.size(), found[i]);
    endfunction

    // mostly smooth values so the trial divisor stays small; a few raw small ones
    function automatic logic [VALUE_BITS-1:0] random_value();
        int unsigned wheel_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        logic [63:0] acc;
        logic [63:0] cand;
        int          kind;
        kind = int'($urandom_range(0, 9));
        if (kind == 0)
            return $urandom_range(0, 3);
        if (kind <= 2)
            return $urandom_range(2, 4095);
        acc = 64'd1;
        repeat ($urandom_range(1, 40)) begin
            cand = acc * wheel_primes[$urandom_range(0, 11)];
            if (cand <= 64'hFFFF_FFFF)
                acc = cand;
        end
        if ($urandom_range(0, 2) == 0) begin
            cand = acc * $urandom_range(2, 2047);
            if (cand <= 64'hFFFF_FFFF)
                acc = cand;
        end
        return acc[VALUE_BITS-1:0];
    endfunction

    // sender: holds an offered item until taken, then waits its drawn gap
    always @(posedge i_clk) begin
        int   gap;
        logic offer;
        gap   = tx_gap;
        offer = i_s_tvalid;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            tx_gap     <= 0;
        end else if (!(i_s_tvalid && !o_s_tready)) begin
            if (i_s_tvalid) begin
                factorize_value(i_s_tdata);
                values_taken <= values_taken + 1;
            end
            offer = 1'b0;
            if (gap > 0) begin
                gap--;
            end else if (pending_values.size() != 0) begin
                i_s_tdata <= pending_values.pop_front();
                offer = 1'b1;
                gap   = idle_draw(values_taken);
            end
            i_s_tvalid <= offer;
            tx_gap     <= gap;
        end
    end

    // long receiver hold-off once, so the output register fills and input stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && values_taken >= 40) begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: checks each taken item against the oldest prediction
    always @(posedge i_clk) begin
        int      w;
        t_factor got;
        t_factor want;
        string   bad;
        w = rx_wait;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_wait    <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = '{prime: o_m_tdata[31:0], power: o_m_tdata[36:32],
                        has_factor: o_m_tuser, last: o_m_tlast};
                if (expected_factors.size() == 0) begin
                    report_mismatch($sformatf("unexpected item, prime %0d", got.prime));
                end else begin
                    want = expected_factors.pop_front();
                    bad  = "";
                    if (got.prime != want.prime)
                        bad = {bad, $sformatf(" prime %0d/%0d", got.prime, want.prime)};
                    if (got.power != want.power)
                        bad = {bad, $sformatf(" exponent %0d/%0d", got.power, want.power)};
                    if (got.has_factor != want.has_factor)
                        bad = {bad, $sformatf(" has_factor %0b/%0b",
                                              got.has_factor, want.has_factor)};
                    if (got.last != want.last)
                        bad = {bad, $sformatf(" tlast %0b/%0b", got.last, want.last)};
                    if (bad != "")
                        report_mismatch({"got/exp:", bad});
                end
                w = idle_draw(results_seen);
                results_seen <= results_seen + 1;
            end else if (w > 0) begin
                w--;
            end
            rx_wait    <= w;
            i_m_tready <= (w == 0) && (hold_left == 0);
        end
    end

    initial begin
        // below two, small primes and powers, squares of primes, nine distinct
        // primes, exponent 31, all-ones, a large prime left over at the end
        logic [VALUE_BITS-1:0] directed[18];
        directed = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd12, 32'd25, 32'd49,
            32'd121, 32'd1018081, 32'd1000003, 32'd223092870, 32'hFFFF_FFFF,
            32'h8000_0000, 32'd4294836225, 32'd3486784401, 32'd1073741823};
        foreach (directed[i])
            pending_values.insert(pending_values.size(), directed[i]);
        repeat (82)
            pending_values.insert(pending_values.size(), random_value());
        values_total = pending_values.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (values_taken < values_total || expected_factors.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (expected_factors.size() != 0)
            report_mismatch($sformatf("%0d items never arrived", expected_factors.size()));

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/pf_pkg.sv
rtl/core/pf_divider.sv
rtl/core/pf_sequencer.sv
rtl/core/prime_factorizer.sv
sim/prime_factorizer_test.sv
